// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the life grid block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define LGS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define LGS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgs_pkg
// Types and constants shared by the life grid block and its channels.
// ----------------------------------------------------------------------------
package lgs_pkg;

   localparam int ROW_W    = 6;
   localparam int COL_W    = 6;
   localparam int CFG_W    = 7;
   localparam int CSR_IDX_W = 1;

   // Smallest grid side and the size registers after reset.
   localparam int MIN_SIDE   = 3;
   localparam logic [CFG_W-1:0] SIDE_RESET = 7'd64;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'd1;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_STEP  = 2'd2,
      CMD_LOAD  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type          command;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             value;
   } req_item_type;

   typedef struct packed {
      logic cell_value;
      logic rolled_back;
   } rsp_item_type;

endpackage

// ===== rtl/lgs_channels.sv =====
// ----------------------------------------------------------------------------
// lgs channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface lgs_req_if;
   import lgs_pkg::*;
   logic         valid;
   logic         ready;
   req_item_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface lgs_rsp_if;
   import lgs_pkg::*;
   logic         valid;
   logic         ready;
   rsp_item_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/life_grid_step_with_border_rollback.sv =====
// ----------------------------------------------------------------------------
// life_grid_step_with_border_rollback
// Grid of one-bit cells with cell access, start pattern load and a B3/S23
// generation step that is discarded when a border cell would come alive.
// ----------------------------------------------------------------------------
//  channel   direction  handshake        content
//  req_ch    in         valid/ready      command, row, col, value
//  rsp_ch    out        valid/ready      cell_value, rolled_back
//  csr_*     in         write enable     index 0 rows_in_use, 1 cols_in_use
//
//  Write and read go through a row read, a row update and a result.
//  Load and step sweep the rows of the grid memory; a kept step then copies the
//  new generation back row by row.
//  After reset a clearing pass writes MAX_ROWS rows, one per cycle, before the
//  first item is taken. A held result stalls only the item behind it at its end.
// ----------------------------------------------------------------------------
module life_grid_step_with_border_rollback #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   lgs_req_if.sink                         req_ch,
   lgs_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [lgs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lgs_pkg::CFG_W-1:0]       csr_wdata
);
   import lgs_pkg::*;
   `include "assert_macros.svh"

   localparam int RW   = $clog2(MAX_ROWS);
   localparam int CW   = $clog2(MAX_COLS);
   localparam int NRW  = $clog2(MAX_ROWS + 1);
   localparam int NCW  = $clog2(MAX_COLS + 1);
   localparam int CNTW = $clog2(MAX_ROWS + 2);

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_CELL   = 7'b0000100,
      ST_STEP   = 7'b0001000,
      ST_COPY   = 7'b0010000,
      ST_LOAD   = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   // Grid and scratch memories, one row word per entry.
   logic [MAX_COLS-1:0] cell_mem [MAX_ROWS];
   logic [MAX_COLS-1:0] next_mem [MAX_ROWS];

   state_type           state_ff, state_in;
   logic [CNTW-1:0]     cnt_ff, cnt_in;
   cmd_type             cmd_ff, cmd_in;
   logic [RW-1:0]       row_addr_ff, row_addr_in;
   logic [CW-1:0]       col_idx_ff, col_idx_in;
   logic                val_ff, val_in;
   logic                inside_ff, inside_in;
   logic [MAX_COLS-1:0] above_ff, above_in;
   logic [MAX_COLS-1:0] cur_ff, cur_in;
   logic                bad_ff, bad_in;
   logic                res_cell_ff, res_cell_in;
   logic                res_roll_ff, res_roll_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_data_ff, rsp_data_in;
   logic [CFG_W-1:0]    rows_cfg_ff, cols_cfg_ff;
   logic [MAX_COLS-1:0] cell_rd_ff, next_rd_ff;

   logic                cell_we, cell_re, next_we, next_re;
   logic [RW-1:0]       cell_waddr, cell_raddr, next_waddr, next_raddr;
   logic [MAX_COLS-1:0] cell_wdata, next_wdata;

   logic [NRW-1:0]      nr;
   logic [NCW-1:0]      nc;
   logic [CNTW-1:0]     nr_p1, row_last, cnt_m1, cnt_m2;
   logic [MAX_COLS-1:0] col_mask, edge_mask, par_even, par_odd;
   logic [MAX_COLS-1:0] below_raw, life_row, step_word, load_word, mod_word;
   logic                row_bad, accept, req_inside;

   // Used grid size, saturated into 3..MAX.
   always_comb begin
      if (int'(rows_cfg_ff) < MIN_SIDE) nr = NRW'(MIN_SIDE);
      else if (int'(rows_cfg_ff) > MAX_ROWS) nr = NRW'(MAX_ROWS);
      else nr = NRW'(rows_cfg_ff);
      if (int'(cols_cfg_ff) < MIN_SIDE) nc = NCW'(MIN_SIDE);
      else if (int'(cols_cfg_ff) > MAX_COLS) nc = NCW'(MAX_COLS);
      else nc = NCW'(cols_cfg_ff);
   end

   assign nr_p1    = CNTW'(nr) + CNTW'(1);
   assign row_last = CNTW'(nr) - CNTW'(1);
   assign cnt_m1   = cnt_ff - CNTW'(1);
   assign cnt_m2   = cnt_ff - CNTW'(2);

   always_comb begin
      for (int c = 0; c < MAX_COLS; c++) begin
         col_mask[c]  = (c < int'(nc));
         edge_mask[c] = (c == 0) || (c == int'(nc) - 1);
         par_even[c]  = ((c & 1) == 0);
         par_odd[c]   = ((c & 1) == 1);
      end
   end

   // One generation of a row: the window rows are masked to the used columns
   // and padded with a dead cell on each side.
   always_comb begin
      logic [MAX_COLS+1:0] up_p, mid_p, dn_p;
      logic [3:0]          n;
      up_p  = {1'b0, above_ff & col_mask, 1'b0};
      mid_p = {1'b0, cur_ff & col_mask, 1'b0};
      dn_p  = {1'b0, below_raw & col_mask, 1'b0};
      for (int c = 0; c < MAX_COLS; c++) begin
         n = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2]) + 4'(mid_p[c]) + 4'(mid_p[c+2])
             + 4'(dn_p[c]) + 4'(dn_p[c+1]) + 4'(dn_p[c+2]);
         life_row[c] = (n == 4'd3) || (mid_p[c+1] && (n == 4'd2));
      end
   end

   assign below_raw = (cnt_ff >= CNTW'(1) && cnt_ff <= CNTW'(nr)) ? cell_rd_ff : '0;
   assign step_word = (life_row & col_mask) | (cur_ff & ~col_mask);
   assign row_bad   = |(life_row & col_mask &
                        (((cnt_m2 == '0) || (cnt_m2 == row_last)) ? col_mask : edge_mask));

   // Start pattern row; columns beyond the used area keep their contents.
   always_comb begin
      logic interior;
      interior  = (cnt_m1 != '0) && (cnt_m1 != row_last);
      load_word = cell_rd_ff & ~col_mask;
      if (interior)
         load_word = load_word | ((cnt_m1[0] ? par_odd : par_even) & col_mask & ~edge_mask);
   end

   always_comb begin
      mod_word             = cell_rd_ff;
      mod_word[col_idx_ff] = val_ff;
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign req_inside   = (int'(req_ch.data.row) < int'(nr)) &&
                         (int'(req_ch.data.col) < int'(nc));

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      cmd_in      = cmd_ff;
      row_addr_in = row_addr_ff;
      col_idx_in  = col_idx_ff;
      val_in      = val_ff;
      inside_in   = inside_ff;
      above_in    = above_ff;
      cur_in      = cur_ff;
      bad_in      = bad_ff;
      res_cell_in = res_cell_ff;
      res_roll_in = res_roll_ff;
      cell_we     = 1'b0;
      cell_waddr  = cnt_m1[RW-1:0];
      cell_wdata  = next_rd_ff;
      cell_re     = 1'b0;
      cell_raddr  = cnt_ff[RW-1:0];
      next_we     = 1'b0;
      next_waddr  = cnt_m2[RW-1:0];
      next_wdata  = step_word;
      next_re     = 1'b0;
      next_raddr  = cnt_ff[RW-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            cell_we    = 1'b1;
            cell_waddr = cnt_ff[RW-1:0];
            cell_wdata = '0;
            cnt_in     = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(MAX_ROWS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in      = req_ch.data.command;
               row_addr_in = RW'(req_ch.data.row);
               col_idx_in  = CW'(req_ch.data.col);
               val_in      = req_ch.data.value;
               inside_in   = req_inside;
               cnt_in      = '0;
               above_in    = '0;
               cur_in      = '0;
               bad_in      = 1'b0;
               res_cell_in = 1'b0;
               res_roll_in = 1'b0;
               unique case (req_ch.data.command)
                  CMD_WRITE, CMD_READ: begin
                     cell_re    = req_inside;
                     cell_raddr = RW'(req_ch.data.row);
                     state_in   = ST_CELL;
                  end
                  CMD_STEP: state_in = ST_STEP;
                  CMD_LOAD: state_in = ST_LOAD;
                  default:  state_in = ST_LOAD;
               endcase
            end
         end
         ST_CELL: begin
            if (cmd_ff == CMD_WRITE && inside_ff) begin
               cell_we    = 1'b1;
               cell_waddr = row_addr_ff;
               cell_wdata = mod_word;
            end
            res_cell_in = (cmd_ff == CMD_READ) && inside_ff && cell_rd_ff[col_idx_ff];
            state_in    = ST_FINISH;
         end
         ST_STEP: begin
            // Read row cnt while row cnt-2 is computed from the window.
            cell_re  = (cnt_ff < CNTW'(nr));
            above_in = cur_ff;
            cur_in   = below_raw;
            if (cnt_ff >= CNTW'(2)) next_we = 1'b1;
            if (cnt_ff >= CNTW'(2)) bad_in = bad_ff | row_bad;
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff == nr_p1) begin
               cnt_in = '0;
               if (bad_ff || row_bad) begin
                  res_roll_in = 1'b1;
                  state_in    = ST_FINISH;
               end else begin
                  state_in = ST_COPY;
               end
            end
         end
         ST_COPY: begin
            next_re = (cnt_ff < CNTW'(nr));
            if (cnt_ff >= CNTW'(1)) cell_we = 1'b1;
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(nr)) state_in = ST_FINISH;
         end
         ST_LOAD: begin
            cell_re = (cnt_ff < CNTW'(nr));
            if (cnt_ff >= CNTW'(1)) begin
               cell_we    = 1'b1;
               cell_wdata = load_word;
            end
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(nr)) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Output register: loaded when an item finishes and the slot is free.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_ch.ready) rsp_valid_in = 1'b0;
      if (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_ch.ready)) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.cell_value  = res_cell_ff;
         rsp_data_in.rolled_back = res_roll_ff;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rows_cfg_ff  <= SIDE_RESET;
         cols_cfg_ff  <= SIDE_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == CSR_ROWS) rows_cfg_ff <= csr_wdata;
         else if (csr_we && csr_index == CSR_COLS) cols_cfg_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      row_addr_ff <= row_addr_in;
      col_idx_ff  <= col_idx_in;
      val_ff      <= val_in;
      inside_ff   <= inside_in;
      above_ff    <= above_in;
      cur_ff      <= cur_in;
      bad_ff      <= bad_in;
      res_cell_ff <= res_cell_in;
      res_roll_ff <= res_roll_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
      if (cell_re) cell_rd_ff <= cell_mem[cell_raddr];
   end

   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_waddr] <= next_wdata;
      if (next_re) next_rd_ff <= next_mem[next_raddr];
   end

   `LGS_ASSERT(a_result_exclusive, clock, reset, rsp_valid_ff |-> !(rsp_data_ff.cell_value && rsp_data_ff.rolled_back), "read value and rollback flag set together")
   `LGS_ASSERT(a_step_keeps_grid, clock, reset, (state_ff == ST_STEP) |-> !cell_we, "grid written during the step sweep")
   `LGS_ASSERT(a_accept_leaves_idle, clock, reset, accept |=> (state_ff != ST_IDLE), "accepted item did not start")
   `LGS_ASSERT(a_step_count_bound, clock, reset, (state_ff == ST_STEP) |-> (cnt_ff <= nr_p1), "step sweep ran past the last row")

endmodule

// ===== tb/lgs_grid_checker.sv =====
// ----------------------------------------------------------------------------
// lgs_grid_checker
// Watches the command, result and register ports of the life grid block,
// keeps its own copy of the grid and the size registers, works out the
// result of every accepted command and compares each returned result with
// the oldest one still awaited.
// ----------------------------------------------------------------------------
module lgs_grid_checker
   import lgs_pkg::*;
#(
   parameter int GRID_ROWS = 64,
   parameter int GRID_COLS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   lgs_req_if                   req_ch,
   lgs_rsp_if                   rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output int                   mismatches,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      req_item_type cmd;
      rsp_item_type rsp;
   } awaited_type;

   logic [GRID_COLS-1:0] life_rows [GRID_ROWS];
   logic [CFG_W-1:0]     rows_reg;
   logic [CFG_W-1:0]     cols_reg;
   awaited_type          awaited [$];
   int                   errors = 0;

   function automatic int clamp_side(input logic [CFG_W-1:0] raw, input int limit);
      if (raw < MIN_SIDE) return MIN_SIDE;
      if (raw > limit) return limit;
      return int'(raw);
   endfunction

   function automatic logic on_edge(input int r, input int c, input int nr, input int nc);
      return r == 0 || c == 0 || r == nr - 1 || c == nc - 1;
   endfunction

   // Computes the whole next generation first; it is only taken over when
   // no border cell of the used area comes out live.
   function automatic logic advance_generation();
      logic [GRID_COLS-1:0] fresh [GRID_ROWS];
      int   nr, nc, live, pr, pc;
      logic born, border_hit;
      nr = clamp_side(rows_reg, GRID_ROWS);
      nc = clamp_side(cols_reg, GRID_COLS);
      fresh = life_rows;
      border_hit = 1'b0;
      for (int r = 0; r < nr; r++) begin
         for (int c = 0; c < nc; c++) begin
            live = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  pr = r + dr;
                  pc = c + dc;
                  if ((dr != 0 || dc != 0) && pr >= 0 && pr < nr && pc >= 0 && pc < nc)
                     live += int'(life_rows[pr][pc]);
               end
            end
            born = life_rows[r][c] ? (live == 2 || live == 3) : (live == 3);
            fresh[r][c] = born;
            if (born && on_edge(r, c, nr, nc)) border_hit = 1'b1;
         end
      end
      if (!border_hit) life_rows = fresh;
      return border_hit;
   endfunction

   function automatic void load_start_pattern();
      int nr, nc;
      nr = clamp_side(rows_reg, GRID_ROWS);
      nc = clamp_side(cols_reg, GRID_COLS);
      for (int r = 0; r < nr; r++) begin
         for (int c = 0; c < nc; c++) begin
            life_rows[r][c] = !on_edge(r, c, nr, nc) && (r[0] == c[0]);
         end
      end
   endfunction

   function automatic rsp_item_type predict_response(input req_item_type it);
      rsp_item_type res;
      logic         in_area;
      res = '0;
      in_area = it.row < clamp_side(rows_reg, GRID_ROWS) &&
                it.col < clamp_side(cols_reg, GRID_COLS);
      case (it.command)
         CMD_WRITE: begin
            if (in_area) life_rows[it.row][it.col] = it.value;
         end
         CMD_READ: begin
            if (in_area) res.cell_value = life_rows[it.row][it.col];
         end
         CMD_STEP: begin
            res.rolled_back = advance_generation();
         end
         default: begin
            load_start_pattern();
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      awaited_type hit;
      awaited_type oldest;
      if (reset) begin
         for (int r = 0; r < GRID_ROWS; r++) life_rows[r] = '0;
         rows_reg = SIDE_RESET;
         cols_reg = SIDE_RESET;
         awaited.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_ROWS) rows_reg = csr_wdata;
            else if (csr_index == CSR_COLS) cols_reg = csr_wdata;
         end
         if (req_ch.valid && req_ch.ready) begin
            hit.cmd = req_ch.data;
            hit.rsp = predict_response(req_ch.data);
            awaited.push_back(hit);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited.size() == 0) begin
               errors++;
               $display("%0t: result with none awaited: cell_value %b rolled_back %b",
                        $time, rsp_ch.data.cell_value, rsp_ch.data.rolled_back);
            end else begin
               oldest = awaited.pop_front();
               if (rsp_ch.data.cell_value !== oldest.rsp.cell_value) begin
                  errors++;
                  $display("%0t: cell_value for command %0d row %0d col %0d: expected %b, actual %b",
                           $time, oldest.cmd.command, oldest.cmd.row, oldest.cmd.col,
                           oldest.rsp.cell_value, rsp_ch.data.cell_value);
               end
               if (rsp_ch.data.rolled_back !== oldest.rsp.rolled_back) begin
                  errors++;
                  $display("%0t: rolled_back for command %0d: expected %b, actual %b",
                           $time, oldest.cmd.command, oldest.rsp.rolled_back,
                           rsp_ch.data.rolled_back);
               end
            end
         end
      end
      mismatches <= errors;
      pending    <= awaited.size();
   end

endmodule

// ===== tb/tb_life_grid_step_with_border_rollback.sv =====
// ----------------------------------------------------------------------------
// tb_life_grid_step_with_border_rollback
// Drives command items into the life grid block under random bursts and
// result back-pressure, moves through a series of grid sizes including the
// saturating extremes, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module tb_life_grid_step_with_border_rollback;
   timeunit 1ns;
   timeprecision 1ps;
   import lgs_pkg::*;

   localparam int GRID_SIDE     = 64;
   localparam int SETTLE_CYCLES = 2 * GRID_SIDE + 12;
   localparam int QUIET_LIMIT   = 4000;
   localparam int LONG_HOLD     = 600;
   localparam int RANDOM_ITEMS  = 1900;
   localparam int PHASES        = 8;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;
   int                   mismatches;
   int                   pending;

   int items_sent;
   int burst_left;
   int cur_rows;
   int cur_cols;
   int hold_requests;
   int phase_rows [PHASES] = '{3, 0, 127, 8, 12, 2, 5, 64};
   int phase_cols [PHASES] = '{3, 127, 1, 8, 20, 64, 5, 64};

   lgs_req_if req_ch();
   lgs_rsp_if rsp_ch();

   life_grid_step_with_border_rollback #(
      .MAX_ROWS (GRID_SIDE),
      .MAX_COLS (GRID_SIDE)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lgs_grid_checker #(
      .GRID_ROWS (GRID_SIDE),
      .GRID_COLS (GRID_SIDE)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offers one item and returns at the edge where it is accepted. Bursts
   // of random length alternate with random gaps; a zero gap keeps valid up.
   task automatic send_cmd(input cmd_type op, input int r, input int c, input logic v);
      req_item_type it;
      int gap;
      it.command = op;
      it.row     = r[ROW_W-1:0];
      it.col     = c[COL_W-1:0];
      it.value   = v;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.data  <= it;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (!(op == CMD_WRITE && (r >= cur_rows || c >= cur_cols))) items_sent++;
   endtask

   task automatic drain_and_settle();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      // A kept step copies its generation back before its result is given.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_grid_size(input int rows_raw, input int cols_raw);
      csr_we    <= 1'b1;
      csr_index <= CSR_ROWS;
      csr_wdata <= rows_raw[CFG_W-1:0];
      @(posedge clock);
      csr_index <= CSR_COLS;
      csr_wdata <= cols_raw[CFG_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      cur_rows = rows_raw < MIN_SIDE ? MIN_SIDE : (rows_raw > GRID_SIDE ? GRID_SIDE : rows_raw);
      cur_cols = cols_raw < MIN_SIDE ? MIN_SIDE : (cols_raw > GRID_SIDE ? GRID_SIDE : cols_raw);
   endtask

   function automatic int rand_row();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(0, GRID_SIDE - 1)
                                         : $urandom_range(0, cur_rows - 1);
   endfunction

   function automatic int rand_col();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(0, GRID_SIDE - 1)
                                         : $urandom_range(0, cur_cols - 1);
   endfunction

   // One short sequence of commands. Most are loads or small seeded patterns
   // followed by steps and reads; the rest are stray writes and noise.
   task automatic run_scene();
      int kind, r0, c0;
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
         send_cmd(CMD_LOAD, rand_row(), rand_col(), 1'($urandom_range(0, 1)));
         repeat ($urandom_range(1, 4)) begin
            send_cmd(CMD_STEP, rand_row(), rand_col(), 1'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 3))
               send_cmd(CMD_READ, rand_row(), rand_col(), 1'($urandom_range(0, 1)));
         end
      end else if (kind < 7) begin
         r0 = (cur_rows >= 5) ? $urandom_range(2, cur_rows - 3) : 1;
         c0 = (cur_cols >= 5) ? $urandom_range(2, cur_cols - 3) : 1;
         for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
               if ($urandom_range(0, 1) == 1)
                  send_cmd(CMD_WRITE, r0 + dr, c0 + dc, $urandom_range(0, 3) != 0);
            end
         end
         repeat ($urandom_range(1, 3)) begin
            send_cmd(CMD_STEP, rand_row(), rand_col(), 1'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 3))
               send_cmd(CMD_READ, r0 + $urandom_range(0, 2) - 1, c0 + $urandom_range(0, 2) - 1,
                        1'($urandom_range(0, 1)));
         end
      end else if (kind == 7) begin
         repeat ($urandom_range(1, 4))
            send_cmd(CMD_WRITE, $urandom_range(0, GRID_SIDE - 1),
                     $urandom_range(0, GRID_SIDE - 1), 1'($urandom_range(0, 1)));
         send_cmd(CMD_STEP, rand_row(), rand_col(), 1'($urandom_range(0, 1)));
      end else begin
         repeat ($urandom_range(1, 6))
            send_cmd(cmd_type'($urandom_range(0, 3)), $urandom_range(0, GRID_SIDE - 1),
                     $urandom_range(0, GRID_SIDE - 1), 1'($urandom_range(0, 1)));
      end
   endtask

   // Result side: stall modes change every so often, and a long hold-off
   // is taken whenever the stimulus asks for one.
   initial begin : rsp_stall_pattern
      int mode, mode_left, hold_left, holds_served, cycle_count;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      holds_served = 0;
      cycle_count = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (holds_served < hold_requests) begin
            holds_served++;
            hold_left = LONG_HOLD;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 300);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
               2:       rsp_ch.ready <= (cycle_count % 4 == 0);
               default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
         else quiet++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      int target;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      csr_we       <= 1'b0;
      csr_index    <= CSR_ROWS;
      csr_wdata    <= '0;
      items_sent    = 0;
      burst_left    = 0;
      hold_requests = 0;
      cur_rows      = GRID_SIDE;
      cur_cols      = GRID_SIDE;
      phase_rows[6] = $urandom_range(3, 20);
      phase_cols[6] = $urandom_range(3, GRID_SIDE);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part on the full grid left by reset.
      send_cmd(CMD_READ,  0,  0, 1'b0);
      send_cmd(CMD_READ,  63, 63, 1'b1);
      send_cmd(CMD_WRITE, 63, 63, 1'b1);
      send_cmd(CMD_READ,  63, 63, 1'b0);
      send_cmd(CMD_WRITE, 0,  0, 1'b1);
      send_cmd(CMD_STEP,  0,  0, 1'b0);
      send_cmd(CMD_READ,  0,  0, 1'b0);
      // A blinker against the top edge grows into the left border column.
      send_cmd(CMD_WRITE, 0,  1, 1'b1);
      send_cmd(CMD_WRITE, 1,  1, 1'b1);
      send_cmd(CMD_WRITE, 2,  1, 1'b1);
      send_cmd(CMD_STEP,  63, 63, 1'b1);
      send_cmd(CMD_READ,  0,  1, 1'b0);
      send_cmd(CMD_WRITE, 0,  1, 1'b0);
      send_cmd(CMD_LOAD,  0,  0, 1'b0);
      send_cmd(CMD_READ,  1,  1, 1'b0);
      send_cmd(CMD_READ,  1,  2, 1'b0);
      send_cmd(CMD_READ,  0,  0, 1'b0);
      send_cmd(CMD_READ,  62, 62, 1'b0);
      send_cmd(CMD_STEP,  0,  0, 1'b0);
      send_cmd(CMD_READ,  32, 32, 1'b0);
      send_cmd(CMD_WRITE, 5,  40, 1'b0);
      send_cmd(CMD_READ,  5,  40, 1'b0);
      items_sent = 0;

      for (int p = 0; p < PHASES; p++) begin
         drain_and_settle();
         set_grid_size(phase_rows[p], phase_cols[p]);
         if (p == 1 || p == 4) hold_requests++;
         target = RANDOM_ITEMS * (p + 1) / PHASES;
         while (items_sent < target) run_scene();
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
